// ===== hdl/tsn_pkg.sv =====
package tsn_pkg;

    // fixed field widths
    localparam int unsigned COORD_WIDTH           = 16;
    localparam int unsigned OUT_WIDTH             = 16;
    localparam int unsigned NORMAL_FRAC_BITS_DEF  = 14;
    localparam logic [31:0] OUT_MAX               = 32'd32767;

    // the largest normalized magnitude lies in [2^29, 2^30)
    localparam int unsigned NORM_WIDTH  = 30;
    localparam int unsigned SQ_WIDTH    = 2 * NORM_WIDTH;
    localparam int unsigned SUM_WIDTH   = 62;
    localparam int unsigned LEN_WIDTH   = 31;
    localparam int unsigned SQRT_STEPS  = 31;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] a_z;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] b_z;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] normal_x;
        logic signed [OUT_WIDTH-1:0] normal_y;
        logic signed [OUT_WIDTH-1:0] normal_z;
        logic                        degenerate;
    } t_out_item;

    // per-item data riding along the square root stages
    typedef struct packed {
        logic [2:0][NORM_WIDTH-1:0] mag;
        logic [2:0]                 neg;
        logic                       degen;
    } t_side;

endpackage

// ===== hdl/triangle_surface_normal.sv =====
// throughput: one triangle per cycle while the output is not stalled; 31 square root
// stages and NORMAL_FRAC_BITS+1 divider stages, one bit per stage, set the depth
// the whole pipeline holds while a result waits on a stalled output
// reset (synchronous, active low) clears all valid bits; data registers keep contents
module triangle_surface_normal import tsn_pkg::*; #(
    parameter int unsigned NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_in,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_out
);

    localparam int unsigned DW  = COORD_WIDTH + 1;
    localparam int unsigned PS  = (DW > 29) ? (COORD_WIDTH - 28) : 0;
    localparam int unsigned UW  = DW - PS;
    localparam int unsigned CRW = 2 * UW + 1;
    localparam int unsigned PW  = $clog2(CRW);
    localparam int unsigned QW  = NORMAL_FRAC_BITS + 1;
    localparam int unsigned NW  = NORM_WIDTH + QW;
    localparam int unsigned DVW = LEN_WIDTH + QW;

    logic w_adv;

    // whole pipeline moves unless the output register is full and stalled
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // stage 1: edge vectors
    logic signed [UW-1:0] w_u [3];
    logic signed [UW-1:0] w_v [3];
    logic signed [DW-1:0] w_du [3];
    logic signed [DW-1:0] w_dv [3];
    logic signed [COORD_WIDTH-1:0] w_a [3];
    logic signed [COORD_WIDTH-1:0] w_b [3];
    logic signed [COORD_WIDTH-1:0] w_c [3];
    logic                 r1_valid;
    logic signed [UW-1:0] r1_u [3];
    logic signed [UW-1:0] r1_v [3];

    assign w_a[0] = i_in.a_x;
    assign w_a[1] = i_in.a_y;
    assign w_a[2] = i_in.a_z;
    assign w_b[0] = i_in.b_x;
    assign w_b[1] = i_in.b_y;
    assign w_b[2] = i_in.b_z;
    assign w_c[0] = i_in.c_x;
    assign w_c[1] = i_in.c_y;
    assign w_c[2] = i_in.c_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_du[i] = DW'(w_c[i]) - DW'(w_a[i]);
            w_dv[i] = DW'(w_b[i]) - DW'(w_a[i]);
            w_u[i]  = UW'(w_du[i] >>> PS);
            w_v[i]  = UW'(w_dv[i] >>> PS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_valid;
        end
        if (w_adv) begin
            r1_u <= w_u;
            r1_v <= w_v;
        end
    end

    // stage 2: six partial products
    logic                     r2_valid;
    logic signed [2*UW-1:0]   r2_p [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid;
        end
        if (w_adv) begin
            r2_p[0] <= r1_u[1] * r1_v[2];
            r2_p[1] <= r1_u[2] * r1_v[1];
            r2_p[2] <= r1_u[2] * r1_v[0];
            r2_p[3] <= r1_u[0] * r1_v[2];
            r2_p[4] <= r1_u[0] * r1_v[1];
            r2_p[5] <= r1_u[1] * r1_v[0];
        end
    end

    // stage 3: cross product
    logic                  r3_valid;
    logic signed [CRW-1:0] r3_n [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid <= r2_valid;
        end
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r3_n[i] <= CRW'(r2_p[2*i]) - CRW'(r2_p[2*i+1]);
            end
        end
    end

    // stage 4: magnitudes and signs
    logic           r4_valid;
    logic [CRW-1:0] r4_mag [3];
    logic [2:0]     r4_neg;
    logic           r4_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_adv) begin
            r4_valid <= r3_valid;
        end
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r4_neg[i] <= r3_n[i][CRW-1];
                r4_mag[i] <= r3_n[i][CRW-1] ? CRW'(-r3_n[i]) : CRW'(r3_n[i]);
            end
            r4_degen <= (r3_n[0] == '0) && (r3_n[1] == '0) && (r3_n[2] == '0);
        end
    end

    // stage 5: leading one of the largest magnitude
    logic [CRW-1:0] w_or;
    logic [PW-1:0]  w_pos;
    logic           r5_valid;
    logic [CRW-1:0] r5_mag [3];
    logic [2:0]     r5_neg;
    logic           r5_degen;
    logic [PW-1:0]  r5_pos;

    always_comb begin
        w_or  = r4_mag[0] | r4_mag[1] | r4_mag[2];
        w_pos = '0;
        for (int j = 0; j < CRW; j++) begin
            if (w_or[j]) begin
                w_pos = PW'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (w_adv) begin
            r5_valid <= r4_valid;
        end
        if (w_adv) begin
            r5_mag   <= r4_mag;
            r5_neg   <= r4_neg;
            r5_degen <= r4_degen;
            r5_pos   <= w_pos;
        end
    end

    // stage 6: normalize so the largest lands in [2^29, 2^30)
    logic [CRW+NORM_WIDTH-2:0] w_sh [3];
    logic                      r6_valid;
    t_side                     r6_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sh[i] = {r5_mag[i], {(NORM_WIDTH-1){1'b0}}} >> r5_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (w_adv) begin
            r6_valid <= r5_valid;
        end
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r6_side.mag[i] <= w_sh[i][NORM_WIDTH-1:0];
            end
            r6_side.neg   <= r5_neg;
            r6_side.degen <= r5_degen;
        end
    end

    // stage 7: squares
    logic                r7_valid;
    logic [SQ_WIDTH-1:0] r7_sq [3];
    t_side               r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (w_adv) begin
            r7_valid <= r6_valid;
        end
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r7_sq[i] <= SQ_WIDTH'(r6_side.mag[i]) * SQ_WIDTH'(r6_side.mag[i]);
            end
            r7_side <= r6_side;
        end
    end

    // stage 8 feeds the square root pipe: sum of squares
    logic                 r_sv    [0:SQRT_STEPS];
    logic [SUM_WIDTH-1:0] r_srem  [0:SQRT_STEPS];
    logic [SUM_WIDTH-1:0] r_sroot [0:SQRT_STEPS];
    t_side                r_sside [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (w_adv) begin
            r_sv[0] <= r7_valid;
        end
        if (w_adv) begin
            r_srem[0]  <= SUM_WIDTH'(r7_sq[0]) + SUM_WIDTH'(r7_sq[1]) + SUM_WIDTH'(r7_sq[2]);
            r_sroot[0] <= '0;
            r_sside[0] <= r7_side;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [SUM_WIDTH:0] BIT = (SUM_WIDTH+1)'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [SUM_WIDTH:0]   w_trial;
        logic [SUM_WIDTH-1:0] n_rem;
        logic [SUM_WIDTH-1:0] n_root;

        always_comb begin
            w_trial = (SUM_WIDTH+1)'(r_sroot[k]) + BIT;
            if ((SUM_WIDTH+1)'(r_srem[k]) >= w_trial) begin
                n_rem  = r_srem[k] - w_trial[SUM_WIDTH-1:0];
                n_root = (r_sroot[k] >> 1) + BIT[SUM_WIDTH-1:0];
            end else begin
                n_rem  = r_srem[k];
                n_root = r_sroot[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_sv[k+1] <= r_sv[k];
            end
            if (w_adv) begin
                r_srem[k+1]  <= n_rem;
                r_sroot[k+1] <= n_root;
                r_sside[k+1] <= r_sside[k];
            end
        end
    end

    // divider entry: rounded numerator, partial remainder split off
    logic                 r_dv    [0:QW];
    logic [LEN_WIDTH-1:0] r_dlen  [0:QW];
    logic [DVW-1:0]       r_dreg  [0:QW][0:2];
    logic [2:0]           r_dneg  [0:QW];
    logic                 r_ddeg  [0:QW];
    logic [LEN_WIDTH-1:0] w_len;
    logic [NW-1:0]        w_num [3];

    assign w_len = r_sroot[SQRT_STEPS][LEN_WIDTH-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = (NW'(r_sside[SQRT_STEPS].mag[i]) << NORMAL_FRAC_BITS)
                     + NW'(w_len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv[0] <= r_sv[SQRT_STEPS];
        end
        if (w_adv) begin
            r_dlen[0] <= w_len;
            for (int i = 0; i < 3; i++) begin
                r_dreg[0][i] <= DVW'(w_num[i]);
            end
            r_dneg[0] <= r_sside[SQRT_STEPS].neg;
            r_ddeg[0] <= r_sside[SQRT_STEPS].degen;
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [LEN_WIDTH:0]   w_r2 [3];
        logic [DVW-1:0]       n_reg [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_r2[i] = {r_dreg[k][i][DVW-1:QW], r_dreg[k][i][QW-1]};
                if (w_r2[i] >= (LEN_WIDTH+1)'(r_dlen[k])) begin
                    n_reg[i] = {LEN_WIDTH'(w_r2[i] - (LEN_WIDTH+1)'(r_dlen[k])),
                                r_dreg[k][i][QW-2:0], 1'b1};
                end else begin
                    n_reg[i] = {w_r2[i][LEN_WIDTH-1:0], r_dreg[k][i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv[k+1] <= r_dv[k];
            end
            if (w_adv) begin
                r_dlen[k+1] <= r_dlen[k];
                for (int i = 0; i < 3; i++) begin
                    r_dreg[k+1][i] <= n_reg[i];
                end
                r_dneg[k+1] <= r_dneg[k];
                r_ddeg[k+1] <= r_ddeg[k];
            end
        end
    end

    // output register: saturate, apply sign, zero on degenerate
    logic [QW-1:0]        w_q   [3];
    logic [OUT_WIDTH-1:0] w_mag [3];
    logic [OUT_WIDTH-1:0] w_cmp [3];
    logic                 r_out_valid;
    t_out_item            r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_q[i] = r_dreg[QW][i][QW-1:0];
            if (32'(w_q[i]) > OUT_MAX) begin
                w_mag[i] = OUT_WIDTH'(OUT_MAX);
            end else begin
                w_mag[i] = OUT_WIDTH'(w_q[i]);
            end
            if (r_ddeg[QW]) begin
                w_cmp[i] = '0;
            end else if (r_dneg[QW][i]) begin
                w_cmp[i] = -w_mag[i];
            end else begin
                w_cmp[i] = w_mag[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_dv[QW];
        end
        if (w_adv) begin
            r_out.normal_x   <= w_cmp[0];
            r_out.normal_y   <= w_cmp[1];
            r_out.normal_z   <= w_cmp[2];
            r_out.degenerate <= r_ddeg[QW];
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // degenerate results carry zero components
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.degenerate |->
            o_out.normal_x == '0 && o_out.normal_y == '0 && o_out.normal_z == '0)
        else $error("degenerate result with nonzero component");

    // a proper unit normal is never all zero
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.degenerate |->
            o_out.normal_x != '0 || o_out.normal_y != '0 || o_out.normal_z != '0)
        else $error("zero normal without degenerate flag");

    // input is held off only while a result waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without pending output");

    // a held result stays in place while the pipeline is frozen
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> o_valid && $stable(r_out) && $stable(r_dv[QW]))
        else $error("pipeline moved during stall");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench import tsn_pkg::*; ();

    localparam int unsigned NFRAC = NORMAL_FRAC_BITS_DEF;
    localparam int unsigned N_RANDOM = 1800;
    localparam longint unsigned CYCLE_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_in;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_out;

    triangle_surface_normal #(.NORMAL_FRAC_BITS(NFRAC)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_in   (i_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out  (o_out)
    );

    t_in_item  tri_pending[$];
    t_out_item normal_expected[$];
    int        mismatch_count;
    int        degen_seen;
    int        out_seen;
    longint unsigned cycle_count;
    bit        quiet_window;
    bit        hold_sender;

    // integer square root, bit by bit
    function automatic longint unsigned floor_sqrt(longint unsigned s);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= root + b) begin
                s -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    // expected unit normal for one triangle
    function automatic t_out_item face_normal(t_in_item t);
        longint signed u[3], v[3], n[3];
        longint unsigned mag[3], m, s, len, q;
        bit neg[3];
        t_out_item r;
        u[0] = longint'(t.c_x) - longint'(t.a_x);
        u[1] = longint'(t.c_y) - longint'(t.a_y);
        u[2] = longint'(t.c_z) - longint'(t.a_z);
        v[0] = longint'(t.b_x) - longint'(t.a_x);
        v[1] = longint'(t.b_y) - longint'(t.a_y);
        v[2] = longint'(t.b_z) - longint'(t.a_z);
        n[0] = u[1] * v[2] - u[2] * v[1];
        n[1] = u[2] * v[0] - u[0] * v[2];
        n[2] = u[0] * v[1] - u[1] * v[0];
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = n[i] < 0;
            mag[i] = neg[i] ? longint'(-n[i]) : longint'(n[i]);
            if (mag[i] > m) m = mag[i];
        end
        r = '0;
        if (m == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        while (m >= (64'd1 << 30)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = floor_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << NFRAC) + (len >> 1)) / len;
            if (q > OUT_MAX) q = OUT_MAX;
            if (neg[i]) q = -q;
            case (i)
                0: r.normal_x = q[15:0];
                1: r.normal_y = q[15:0];
                default: r.normal_z = q[15:0];
            endcase
        end
        return r;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_triangle();
        t_in_item t;
        t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
        t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
        t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
        case ($urandom_range(0, 15))
            // collapsed: coincident vertices
            0: begin t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z; end
            // collinear: c is a multiple of b about a
            1: begin
                t.a_x = 16'($urandom_range(0, 200)) - 16'd100;
                t.a_y = 16'($urandom_range(0, 200)) - 16'd100;
                t.a_z = 16'($urandom_range(0, 200)) - 16'd100;
                t.b_x = t.a_x + 16'($urandom_range(0, 200)) - 16'd100;
                t.b_y = t.a_y + 16'($urandom_range(0, 200)) - 16'd100;
                t.b_z = t.a_z + 16'($urandom_range(0, 200)) - 16'd100;
                t.c_x = t.a_x + 16'd3 * (t.b_x - t.a_x);
                t.c_y = t.a_y + 16'd3 * (t.b_y - t.a_y);
                t.c_z = t.a_z + 16'd3 * (t.b_z - t.a_z);
            end
            // axis-aligned face in the z plane
            2: begin t.b_z = t.a_z; t.c_z = t.a_z; end
            default: ;
        endcase
        return t;
    endfunction

    function automatic t_in_item make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                          int cx, int cy, int cz);
        t_in_item t;
        t.a_x = 16'(ax); t.a_y = 16'(ay); t.a_z = 16'(az);
        t.b_x = 16'(bx); t.b_y = 16'(by); t.b_z = 16'(bz);
        t.c_x = 16'(cx); t.c_y = 16'(cy); t.c_z = 16'(cz);
        return t;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // reset and stimulus
    initial begin
        i_rst_n = 1'b0;
        hold_sender = 1'b1;
        // all zero and all equal vertices
        tri_pending.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        tri_pending.push_back(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                                       -32768, -32768, -32768));
        // unit faces on each axis
        tri_pending.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256));
        tri_pending.push_back(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0));
        // smallest nonzero cross product
        tri_pending.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        // widest differences
        tri_pending.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                       -32768, 32767, -32768));
        tri_pending.push_back(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                                       32767, -32768, 32767));
        tri_pending.push_back(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                       -32768, -32768, 32767));
        tri_pending.push_back(make_tri(32767, -32768, 0, -32768, 32767, 0,
                                       32767, 32767, -32768));
        // diagonal normal, collinear and opposite-direction degenerate cases
        tri_pending.push_back(make_tri(0, 0, 0, 256, -256, 0, 0, 256, -256));
        tri_pending.push_back(make_tri(10, 20, 30, 20, 40, 60, 30, 60, 90));
        tri_pending.push_back(make_tri(0, 0, 0, 100, 100, 100, -100, -100, -100));
        tri_pending.push_back(make_tri(1, 2, 3, -1, -2, -3, 5, 7, -9));
        for (int k = 0; k < 6; k++) tri_pending.push_back(rand_triangle());
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        hold_sender <= 1'b0;
        // let the directed part drain fully before random traffic
        wait (tri_pending.size() == 0);
        wait (normal_expected.size() == 0);
        for (int k = 0; k < N_RANDOM; k++) tri_pending.push_back(rand_triangle());
        wait (tri_pending.size() == 0);
        wait (normal_expected.size() == 0);
        repeat (80) @(posedge i_clk);
        $display("covered %0d results, %0d degenerate faces, %0d mismatches",
                 out_seen, degen_seen, mismatch_count);
        if (mismatch_count == 0 && normal_expected.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // quiet window with no idling and a cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        quiet_window <= (cycle_count >= 1000) && (cycle_count < 1400);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        cycle_count = 0;
        quiet_window = 1'b0;
        mismatch_count = 0;
        degen_seen = 0;
        out_seen = 0;
    end

    // driver: present triangles, hold while stalled
    initial begin
        i_valid = 1'b0;
        i_in = '0;
        i_stall = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            normal_expected.push_back(face_normal(i_in));
        end
        if (!i_valid || !o_stall) begin
            if (i_rst_n && !hold_sender && tri_pending.size() != 0 &&
                (quiet_window || $urandom_range(0, 99) >= 12)) begin
                i_in <= tri_pending.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= !quiet_window && ($urandom_range(0, 99) < 12);
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_valid && !i_stall) begin
            out_seen <= out_seen + 1;
            if (normal_expected.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result transfer %h", o_out);
            end else begin
                exp_item = normal_expected.pop_front();
                if (exp_item.degenerate) degen_seen <= degen_seen + 1;
                if (o_out !== exp_item) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display({"mismatch: exp x=%0d y=%0d z=%0d dg=%0b",
                                  " got x=%0d y=%0d z=%0d dg=%0b"},
                                 exp_item.normal_x, exp_item.normal_y, exp_item.normal_z,
                                 exp_item.degenerate, o_out.normal_x, o_out.normal_y,
                                 o_out.normal_z, o_out.degenerate);
                end
            end
        end
    end

endmodule

// ===== filelist.f =====
hdl/tsn_pkg.sv
hdl/triangle_surface_normal.sv
tb/testbench.sv
